### hw/rtl/irs_pkg.sv
`timescale 1ns / 1ps
package irs_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 16;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;

    localparam logic [1:0] MODE_NEAREST  = 2'd0;
    localparam logic [1:0] MODE_AVERAGE  = 2'd1;
    localparam logic [1:0] MODE_BILINEAR = 2'd2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_SRC_W     = 3'd1;
    localparam logic [2:0] REG_SRC_H     = 3'd2;
    localparam logic [2:0] REG_SCALE_X   = 3'd3;
    localparam logic [2:0] REG_SCALE_Y   = 3'd4;
    localparam logic [2:0] REG_GAIN      = 3'd5;
    localparam logic [2:0] REG_HAS_ALPHA = 3'd6;

    typedef struct packed {
        logic       opcode;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } result_t;
endpackage

### hw/rtl/irs_frame_store.sv
`timescale 1ns / 1ps
module irs_frame_store
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [irs_pkg::AW-1:0] addr,
    input  logic [31:0]            wdata,
    output logic [31:0]            rdata
);
    logic [31:0] mem [0:(1 << irs_pkg::AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hw/rtl/image_resample_scaler.sv
`timescale 1ns / 1ps
// Image resampler with a built-in single-port frame store.
// Configuration: APB-style port, register i at byte address 4*i, written in
// the access phase; pready is tied high, reads return the register value.
// Commands: a request is taken when start is high and busy is low.
//  Load (opcode 0): writes one RGBA pixel into the store, no result; busy
//  stays low, so loads can follow back to back.
//  Request (opcode 1): busy rises for the whole request. S_MUL multiplies
//  coordinates by scale, S_ADDR clamps and derives neighbours, then for each
//  tap S_READ issues the store read, S_READ again captures the data with its
//  bilinear weight and S_ACC accumulates (1 tap for nearest, 4 for average
//  and bilinear), then the gain state S_GAIN and the output state S_OUT.
//  valid rises in the same cycle that busy falls, and the next request may
//  be taken in that same cycle. The single store port and the tap loop set
//  the rate.
// The receiver cannot stall; each result is shown exactly once.
// Reset: registers return to defaults (nearest, 256x256, scale 1.0,
// gain 1.0, alpha present). The store is not cleared; reading a pixel
// never loaded gives undefined data.
module image_resample_scaler
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             start,
    output logic             busy,
    input  irs_pkg::cmd_t    cmd,
    output logic             valid,
    output irs_pkg::result_t result
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADDR, S_READ, S_ACC, S_GAIN, S_OUT} state_t;

    logic [1:0]  mode_reg;
    logic [8:0]  src_w_reg, src_h_reg, gain_reg;
    logic [23:0] scale_x_reg, scale_y_reg;
    logic        has_alpha_reg;

    state_t      state_reg;
    logic [7:0]  dcol_reg, drow_reg;
    logic [31:0] px_reg, py_reg;
    logic [7:0]  ix_reg, iy_reg, x1_reg, y1_reg;
    logic [2:0]  tap_reg;
    logic        rd_pend_reg;
    logic [1:0]  acc_tap_reg;
    logic [41:0] acc_reg [0:3];
    logic [7:0]  res_reg [0:3];

    logic [2:0]  cfg_idx;
    assign cfg_idx = paddr[4:2];
    assign pready = 1'b1;

    always_comb
    begin
        case (cfg_idx)
            irs_pkg::REG_MODE:      prdata = {30'd0, mode_reg};
            irs_pkg::REG_SRC_W:     prdata = {23'd0, src_w_reg};
            irs_pkg::REG_SRC_H:     prdata = {23'd0, src_h_reg};
            irs_pkg::REG_SCALE_X:   prdata = {8'd0, scale_x_reg};
            irs_pkg::REG_SCALE_Y:   prdata = {8'd0, scale_y_reg};
            irs_pkg::REG_GAIN:      prdata = {23'd0, gain_reg};
            irs_pkg::REG_HAS_ALPHA: prdata = {31'd0, has_alpha_reg};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= irs_pkg::MODE_NEAREST;
            src_w_reg     <= 9'd256;
            src_h_reg     <= 9'd256;
            scale_x_reg   <= 24'd65536;
            scale_y_reg   <= 24'd65536;
            gain_reg      <= 9'd256;
            has_alpha_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                irs_pkg::REG_MODE:      mode_reg      <= pwdata[1:0];
                irs_pkg::REG_SRC_W:     src_w_reg     <= pwdata[8:0];
                irs_pkg::REG_SRC_H:     src_h_reg     <= pwdata[8:0];
                irs_pkg::REG_SCALE_X:   scale_x_reg   <= pwdata[23:0];
                irs_pkg::REG_SCALE_Y:   scale_y_reg   <= pwdata[23:0];
                irs_pkg::REG_GAIN:      gain_reg      <= pwdata[8:0];
                irs_pkg::REG_HAS_ALPHA: has_alpha_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // effective limits
    logic [8:0] wm1, hm1;
    logic [8:0] gain_eff;
    logic       avg_mode, bil_mode;
    always_comb
    begin
        wm1 = (src_w_reg == 9'd0) ? 9'd0 : ((src_w_reg > 9'd256) ? 9'd255 : src_w_reg - 9'd1);
        hm1 = (src_h_reg == 9'd0) ? 9'd0 : ((src_h_reg > 9'd256) ? 9'd255 : src_h_reg - 9'd1);
        gain_eff = (gain_reg > 9'd256) ? 9'd256 : gain_reg;
        avg_mode = (mode_reg == irs_pkg::MODE_AVERAGE);
        bil_mode = (mode_reg == irs_pkg::MODE_BILINEAR);
    end

    logic [15:0] ipx, ipy;
    logic [15:0] fx, fy;
    logic [7:0]  ixc, iyc;
    logic [8:0]  hx, hy;
    logic [9:0]  sx, sy;
    logic [7:0]  x1c, y1c;
    always_comb
    begin
        ipx = px_reg[31:16];
        ipy = py_reg[31:16];
        fx  = px_reg[15:0];
        fy  = py_reg[15:0];
        ixc = ({7'd0, ipx} > {14'd0, wm1}) ? wm1[7:0] : ipx[7:0];
        iyc = ({7'd0, ipy} > {14'd0, hm1}) ? hm1[7:0] : ipy[7:0];
        hx = avg_mode ? {2'd0, scale_x_reg[23:17]} : 9'd1;
        hy = avg_mode ? {2'd0, scale_y_reg[23:17]} : 9'd1;
        sx = {2'd0, ixc} + {1'b0, hx};
        sy = {2'd0, iyc} + {1'b0, hy};
        x1c = (sx > {1'b0, wm1}) ? wm1[7:0] : sx[7:0];
        y1c = (sy > {1'b0, hm1}) ? hm1[7:0] : sy[7:0];
    end

    // store port
    logic                   st_we;
    logic [irs_pkg::AW-1:0] st_addr;
    logic [31:0]            st_rdata;
    logic [7:0]             tx, ty;
    logic                   load_go;
    assign load_go = start && !busy && (cmd.opcode == irs_pkg::OP_LOAD);
    always_comb
    begin
        tx = tap_reg[1] ? x1_reg : ix_reg;
        ty = tap_reg[0] ? y1_reg : iy_reg;
        st_we = load_go;
        st_addr = load_go ? {cmd.row, cmd.col} : {ty, tx};
    end

    irs_frame_store u_store
    (
        .clk   (clk),
        .we    (st_we),
        .addr  (st_addr),
        .wdata ({cmd.alpha_in, cmd.blue_in, cmd.green_in, cmd.red_in}),
        .rdata (st_rdata)
    );

    // weight for current accumulated tap (tap index bit1 = x1, bit0 = y1)
    logic [31:0] pix;
    logic [16:0] wx, wy;
    logic [33:0] wxy;
    assign pix = has_alpha_reg ? st_rdata : {8'hFF, st_rdata[23:0]};
    always_comb
    begin
        wx = acc_tap_reg[1] ? {1'b0, fx} : 17'h10000 - {1'b0, fx};
        wy = acc_tap_reg[0] ? {1'b0, fy} : 17'h10000 - {1'b0, fy};
        wxy = wx * wy;
    end

    logic [33:0] w_reg;
    logic [31:0] pix_reg;
    logic [41:0] mulc [0:3];
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            mulc[c] = {34'd0, pix_reg[8*c +: 8]} * {8'd0, w_reg};
        end
    end

    logic [50:0] amul;
    assign amul = {9'd0, acc_reg[3]} * {42'd0, gain_eff};

    logic [2:0] ntaps;
    assign ntaps = (avg_mode || bil_mode) ? 3'd4 : 3'd1;
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid       <= 1'b0;
            rd_pend_reg <= 1'b0;
            tap_reg     <= 3'd0;
            acc_tap_reg <= 2'd0;
        end
        else
        begin
            valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && cmd.opcode == irs_pkg::OP_REQUEST)
                    begin
                        dcol_reg  <= cmd.col;
                        drow_reg  <= cmd.row;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    px_reg    <= {24'd0, dcol_reg} * {8'd0, scale_x_reg};
                    py_reg    <= {24'd0, drow_reg} * {8'd0, scale_y_reg};
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    ix_reg <= ixc;
                    iy_reg <= iyc;
                    x1_reg <= x1c;
                    y1_reg <= y1c;
                    tap_reg <= 3'd0;
                    rd_pend_reg <= 1'b0;
                    for (int c = 0; c < 4; c++)
                    begin
                        acc_reg[c] <= 42'd0;
                    end
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    // first visit issues the tap's read, second visit captures its data
                    if (rd_pend_reg)
                    begin
                        pix_reg     <= pix;
                        w_reg       <= bil_mode ? wxy : 34'd1;
                        acc_tap_reg <= tap_reg[1:0] - 2'd1;
                        state_reg   <= S_ACC;
                        rd_pend_reg <= 1'b0;
                    end
                    else
                    begin
                        acc_tap_reg <= tap_reg[1:0];
                        tap_reg     <= tap_reg + 3'd1;
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_ACC:
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        acc_reg[c] <= acc_reg[c] + mulc[c];
                    end
                    if (tap_reg == ntaps)
                    begin
                        state_reg <= S_GAIN;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_GAIN:
                begin
                    if (bil_mode)
                    begin
                        res_reg[0] <= acc_reg[0][39:32];
                        res_reg[1] <= acc_reg[1][39:32];
                        res_reg[2] <= acc_reg[2][39:32];
                        res_reg[3] <= amul[47:40];
                    end
                    else if (avg_mode)
                    begin
                        res_reg[0] <= acc_reg[0][9:2];
                        res_reg[1] <= acc_reg[1][9:2];
                        res_reg[2] <= acc_reg[2][9:2];
                        res_reg[3] <= 8'(({9'd0, acc_reg[3][9:2]} * gain_eff) >> 8);
                    end
                    else
                    begin
                        res_reg[0] <= acc_reg[0][7:0];
                        res_reg[1] <= acc_reg[1][7:0];
                        res_reg[2] <= acc_reg[2][7:0];
                        res_reg[3] <= 8'(({9'd0, acc_reg[3][7:0]} * gain_eff) >> 8);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    valid     <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result.out_red   = res_reg[0];
    assign result.out_green = res_reg[1];
    assign result.out_blue  = res_reg[2];
    assign result.out_alpha = res_reg[3];
endmodule
